### sv/tqws_pkg.sv
// ----------------------------------------------------------------------------
// tqws_pkg
// Shared types and constants of the two-queue weighted server.
// ----------------------------------------------------------------------------
package tqws_pkg;

    // Payload widths.
    localparam int CMD_W  = 2;
    localparam int DATA_W = 32;

    // Default depth of each value queue.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Command codes on the input channel.
    localparam logic [CMD_W-1:0] CMD_PUSH_NORMAL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_PREF   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SERVE       = 2'd2;

    // Result status codes.
    localparam logic STATUS_SERVED  = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    // Turn counter: zero serves normal, other counts serve preferred.
    localparam logic [1:0] TURN_NORMAL = 2'd0;
    localparam logic [1:0] TURN_RESET  = 2'd1;

    typedef logic signed [DATA_W-1:0] t_value;

    // Operation kinds after classification in the front end.
    typedef enum logic [1:0] {
        OP_PUSH_NORMAL,
        OP_PUSH_PREF,
        OP_SERVE
    } t_op_kind;

    typedef struct packed {
        t_op_kind kind;
        t_value   value;
    } t_op;

    // Back-end sequencer states.
    typedef enum logic {
        ST_EXEC,
        ST_FETCH
    } t_back_state;

    // Control from the back end to one value queue.
    typedef struct packed {
        logic   push;
        logic   pop;
        t_value data;
    } t_queue_ctrl;

    // Status of one value queue.
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

### sv/tqws_if.sv
// ----------------------------------------------------------------------------
// tqws_if
// Valid/ready channel interfaces for commands and results.
// ----------------------------------------------------------------------------
interface tqws_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [tqws_pkg::CMD_W-1:0]  command;
    tqws_pkg::t_value            push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface tqws_res_if;
    logic             valid;
    logic             ready;
    tqws_pkg::t_value served_value;
    logic             from_preferred;
    logic             status;

    modport source (output valid, output served_value, output from_preferred,
                     output status, input ready);
    modport sink   (input valid, input served_value, input from_preferred,
                     input status, output ready);
endinterface

### sv/tqws_front.sv
// ----------------------------------------------------------------------------
// tqws_front
// Accepts command beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tqws_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tqws_cmd_if.sink        i_cmd,
    output tqws_pkg::t_op   o_op,
    output logic            o_op_valid,
    input  logic            i_op_ready
);

    tqws_pkg::t_op r_slot [2];
    logic          r_head;
    logic          r_tail;
    logic [1:0]    r_count;

    tqws_pkg::t_op n_op;
    logic          n_keep;
    logic          accept;
    logic          consume;

    // Classify the incoming command; the unused code is accepted and dropped.
    always_comb begin
        n_op.value = i_cmd.push_value;
        n_op.kind  = tqws_pkg::OP_SERVE;
        n_keep     = 1'b1;
        unique case (i_cmd.command)
            tqws_pkg::CMD_PUSH_NORMAL: n_op.kind = tqws_pkg::OP_PUSH_NORMAL;
            tqws_pkg::CMD_PUSH_PREF:   n_op.kind = tqws_pkg::OP_PUSH_PREF;
            tqws_pkg::CMD_SERVE:       n_op.kind = tqws_pkg::OP_SERVE;
            default:                   n_keep    = 1'b0;
        endcase
    end

    assign i_cmd.ready = (r_count != 2'd2);
    assign accept      = i_cmd.valid && i_cmd.ready && n_keep;
    assign consume     = o_op_valid && i_op_ready;
    assign o_op_valid  = (r_count != 2'd0);
    assign o_op        = r_slot[r_head];

    // Queue pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_tail  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (accept) begin
                r_tail <= ~r_tail;
            end
            if (consume) begin
                r_head <= ~r_head;
            end
            if (accept && !consume) begin
                r_count <= r_count + 2'd1;
            end else if (consume && !accept) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot[r_tail] <= n_op;
        end
    end

endmodule

### sv/tqws_queue.sv
// ----------------------------------------------------------------------------
// tqws_queue
// Bounded FIFO of values in a memory with a registered read port.
// ----------------------------------------------------------------------------
module tqws_queue #(
    parameter int DEPTH = tqws_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tqws_pkg::t_queue_ctrl   i_ctrl,
    output tqws_pkg::t_queue_status o_status,
    output tqws_pkg::t_value        o_rd_data
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    tqws_pkg::t_value r_mem [DEPTH];
    tqws_pkg::t_value r_rd_data;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [FILL_W-1:0] r_fill;

    assign o_status.empty = (r_fill == '0);
    assign o_status.full  = (r_fill == FILL_W'(DEPTH));
    assign o_rd_data      = r_rd_data;

    // Pointers wrap explicitly so that any depth works.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_ctrl.push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_ctrl.pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_ctrl.push && !i_ctrl.pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (i_ctrl.pop && !i_ctrl.push) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

    // Memory write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_wr_ptr] <= i_ctrl.data;
        end
        if (i_ctrl.pop) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

endmodule

### sv/tqws_back.sv
// ----------------------------------------------------------------------------
// tqws_back
// Carries out operations against the two queues, arbitrates serves with the
// weighted turn counter and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module tqws_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tqws_pkg::t_op           i_op,
    input  logic                    i_op_valid,
    output logic                    o_op_ready,
    output tqws_pkg::t_queue_ctrl   o_ctrl_n,
    output tqws_pkg::t_queue_ctrl   o_ctrl_p,
    input  tqws_pkg::t_queue_status i_stat_n,
    input  tqws_pkg::t_queue_status i_stat_p,
    input  tqws_pkg::t_value        i_rd_n,
    input  tqws_pkg::t_value        i_rd_p,
    tqws_res_if.source              o_res
);

    tqws_pkg::t_back_state r_state;
    tqws_pkg::t_back_state n_state;
    logic [1:0]            r_turn;
    logic [1:0]            n_turn;
    logic                  r_sel;
    logic                  r_out_valid;
    tqws_pkg::t_value      r_out_value;
    logic                  r_out_pref;
    logic                  r_out_status;

    logic out_free;
    logic issue;
    logic sel_pref;
    logic load_drop;
    logic drop_pref;

    assign out_free = !r_out_valid || o_res.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tqws_pkg::ST_EXEC:  n_state = issue ? tqws_pkg::ST_FETCH : tqws_pkg::ST_EXEC;
            tqws_pkg::ST_FETCH: n_state = tqws_pkg::ST_EXEC;
            default:            n_state = tqws_pkg::ST_EXEC;
        endcase
    end

    // Operation decode, queue control and turn update.
    always_comb begin
        o_op_ready    = 1'b0;
        o_ctrl_n      = '0;
        o_ctrl_p      = '0;
        o_ctrl_n.data = i_op.value;
        o_ctrl_p.data = i_op.value;
        issue         = 1'b0;
        sel_pref      = 1'b0;
        load_drop     = 1'b0;
        drop_pref     = 1'b0;
        n_turn        = r_turn;
        if (r_state == tqws_pkg::ST_EXEC && i_op_valid && out_free) begin
            o_op_ready = 1'b1;
            unique case (i_op.kind)
                tqws_pkg::OP_PUSH_NORMAL: begin
                    if (i_stat_n.full) begin
                        load_drop = 1'b1;
                    end else begin
                        o_ctrl_n.push = 1'b1;
                    end
                end
                tqws_pkg::OP_PUSH_PREF: begin
                    drop_pref = 1'b1;
                    if (i_stat_p.full) begin
                        load_drop = 1'b1;
                    end else begin
                        o_ctrl_p.push = 1'b1;
                    end
                end
                tqws_pkg::OP_SERVE: begin
                    // Weighted choice only when both queues hold entries.
                    priority if (i_stat_n.empty && i_stat_p.empty) begin
                        issue = 1'b0;
                    end else if (i_stat_p.empty) begin
                        issue    = 1'b1;
                        sel_pref = 1'b0;
                        n_turn   = tqws_pkg::TURN_RESET;
                    end else if (i_stat_n.empty) begin
                        issue    = 1'b1;
                        sel_pref = 1'b1;
                        n_turn   = tqws_pkg::TURN_RESET;
                    end else begin
                        issue    = 1'b1;
                        sel_pref = (r_turn != tqws_pkg::TURN_NORMAL);
                        n_turn   = r_turn + 2'd1;
                    end
                    o_ctrl_n.pop = issue && !sel_pref;
                    o_ctrl_p.pop = issue && sel_pref;
                end
                default: begin
                    o_op_ready = 1'b1;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tqws_pkg::ST_EXEC;
            r_turn      <= tqws_pkg::TURN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_turn  <= n_turn;
            if (load_drop || r_state == tqws_pkg::ST_FETCH) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload and serve selection.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_sel <= sel_pref;
        end
        if (load_drop) begin
            r_out_value  <= '0;
            r_out_pref   <= drop_pref;
            r_out_status <= tqws_pkg::STATUS_DROPPED;
        end else if (r_state == tqws_pkg::ST_FETCH) begin
            r_out_value  <= r_sel ? i_rd_p : i_rd_n;
            r_out_pref   <= r_sel;
            r_out_status <= tqws_pkg::STATUS_SERVED;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.served_value   = r_out_value;
    assign o_res.from_preferred = r_out_pref;
    assign o_res.status         = r_out_status;

endmodule

### sv/two_queue_weighted_server_core.sv
// ----------------------------------------------------------------------------
// two_queue_weighted_server_core
// Two bounded value queues, normal and preferred, served three to one.
// ----------------------------------------------------------------------------
// Commands enter through a two-entry front buffer and are carried out by the
// back end one at a time. A push finishes in the exec state and a serve goes
// on to fetch, as each queue memory has a registered read port and the served
// value is ready the cycle after the pop. A push to a full queue gives one
// result beat with status set and a zero value; a successful push, a serve
// with both queues empty and the unused command code give no beat. When both
// queues hold entries, serves follow the pattern three preferred, one normal;
// when only one holds entries it is served and the turn counter returns to
// one. The finished result sits in an output register; the back end takes its
// next command only when that register is empty or is being taken in the
// same cycle, so a beat that waits stalls the back end, while the front buffer
// keeps accepting commands until both of its entries are full. Queue memories
// need no clearing after reset.
module two_queue_weighted_server_core #(
    parameter int QUEUE_DEPTH = tqws_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tqws_cmd_if.sink    i_cmd,
    tqws_res_if.source  o_res
);

    tqws_pkg::t_op           op;
    logic                    op_valid;
    logic                    op_ready;
    tqws_pkg::t_queue_ctrl   ctrl_n;
    tqws_pkg::t_queue_ctrl   ctrl_p;
    tqws_pkg::t_queue_status stat_n;
    tqws_pkg::t_queue_status stat_p;
    tqws_pkg::t_value        rd_n;
    tqws_pkg::t_value        rd_p;

    // Front end: accept and classify.
    tqws_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .o_op       (op),
        .o_op_valid (op_valid),
        .i_op_ready (op_ready)
    );

    // Value queues.
    tqws_queue #(.DEPTH(QUEUE_DEPTH)) u_queue_n (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl_n),
        .o_status  (stat_n),
        .o_rd_data (rd_n)
    );

    tqws_queue #(.DEPTH(QUEUE_DEPTH)) u_queue_p (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl_p),
        .o_status  (stat_p),
        .o_rd_data (rd_p)
    );

    // Back end: execute and arbitrate.
    tqws_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op),
        .i_op_valid (op_valid),
        .o_op_ready (op_ready),
        .o_ctrl_n   (ctrl_n),
        .o_ctrl_p   (ctrl_p),
        .i_stat_n   (stat_n),
        .i_stat_p   (stat_p),
        .i_rd_n     (rd_n),
        .i_rd_p     (rd_p),
        .o_res      (o_res)
    );

    // A push never lands in a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((ctrl_n.push && stat_n.full) || (ctrl_p.push && stat_p.full)))
        else $error("push into a full queue");

    // A pop never comes from an empty queue.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((ctrl_n.pop && stat_n.empty) || (ctrl_p.pop && stat_p.empty)))
        else $error("pop from an empty queue");

    // A serve pops at most one queue.
    a_single_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctrl_n.pop && ctrl_p.pop))
        else $error("both queues popped at once");

    // A pop is followed by a valid served beat.
    a_pop_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl_n.pop || ctrl_p.pop) |=> ##1
        (o_res.valid && o_res.status == tqws_pkg::STATUS_SERVED))
        else $error("pop without a served beat");

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the two-queue weighted server.
// ----------------------------------------------------------------------------
// Commands are driven on the command channel at the falling clock edge.
// Every accepted command is also applied to a behavioral copy of the two
// queues and the turn counter in this file, and that copy predicts the
// result beat, if any. Result beats are sampled at the rising edge and
// compared field by field, in order, with the predicted beats. A short
// directed test covers the field extremes, each command and the corner
// cases. Random traffic in bursts then fills and drains both queues under
// three idling settings of the two channel ends.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tqws_pkg::*;

    localparam int          DEPTH       = 16;
    localparam int          TAIL_CYCLES = 20;
    localparam int          MAX_REPORTS = 10;
    // The block ignores this code; the package gives it no name.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One result beat as predicted.
    typedef struct {
        t_value value;
        logic   pref;
        logic   status;
    } served_beat_t;

    logic i_clk;
    logic i_rst_n;

    tqws_cmd_if cmd_bus ();
    tqws_res_if res_bus ();

    two_queue_weighted_server_core #(
        .QUEUE_DEPTH (DEPTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    // Behavioral copy of the block state.
    t_value       normal_q[$];
    t_value       pref_q[$];
    logic [1:0]   turn;

    // Beats still owed by the block, oldest first.
    served_beat_t pending_beats[$];

    int fail_count;
    int send_idle_pct;
    int recv_idle_pct;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Receiver side: ready is redrawn at every falling edge.
    initial begin
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Applies one accepted command to the queue copy and records its beat.
    function automatic void predict_served(input logic [CMD_W-1:0] c, input t_value v);
        served_beat_t beat;
        logic         use_pref;
        beat.value  = '0;
        beat.pref   = 1'b0;
        beat.status = STATUS_SERVED;
        case (c)
            CMD_PUSH_NORMAL: begin
                if (normal_q.size() < DEPTH) begin
                    normal_q.push_back(v);
                end else begin
                    beat.status = STATUS_DROPPED;
                    pending_beats.push_back(beat);
                end
            end
            CMD_PUSH_PREF: begin
                if (pref_q.size() < DEPTH) begin
                    pref_q.push_back(v);
                end else begin
                    beat.pref   = 1'b1;
                    beat.status = STATUS_DROPPED;
                    pending_beats.push_back(beat);
                end
            end
            CMD_SERVE: begin
                if (normal_q.size() != 0 || pref_q.size() != 0) begin
                    // Only one queue holding entries resets the turn count.
                    if (pref_q.size() == 0) begin
                        use_pref = 1'b0;
                        turn     = TURN_RESET;
                    end else if (normal_q.size() == 0) begin
                        use_pref = 1'b1;
                        turn     = TURN_RESET;
                    end else begin
                        use_pref = (turn != TURN_NORMAL);
                        turn     = turn + 2'd1;
                    end
                    beat.pref  = use_pref;
                    beat.value = use_pref ? pref_q.pop_front() : normal_q.pop_front();
                    pending_beats.push_back(beat);
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Result check: each beat against the oldest predicted beat.
    always @(posedge i_clk) begin : check_results
        served_beat_t want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_beats.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("unexpected beat: value %0d pref %0b status %0b",
                             res_bus.served_value, res_bus.from_preferred, res_bus.status);
                end
            end else begin
                want = pending_beats.pop_front();
                if (res_bus.served_value !== want.value ||
                    res_bus.from_preferred !== want.pref ||
                    res_bus.status !== want.status) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("mismatch: value %0d/%0d pref %0b/%0b status %0b/%0b (exp/act)",
                                 want.value, res_bus.served_value, want.pref,
                                 res_bus.from_preferred, want.status, res_bus.status);
                    end
                end
            end
        end
    end

    // Sends one command beat; starts and ends just after a falling edge.
    task automatic send_cmd(input logic [CMD_W-1:0] c, input t_value v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.command    <= c;
        cmd_bus.push_value <= v;
        do @(posedge i_clk); while (!cmd_bus.ready);
        predict_served(c, v);
        @(negedge i_clk);
    endtask

    // Holds the sender off until every predicted beat has arrived.
    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        do @(negedge i_clk); while (pending_beats.size() != 0);
    endtask

    // Random value with the extremes drawn often.
    function automatic t_value rand_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Field extremes, every command and the corner cases.
    task automatic test_directed();
        send_cmd(CMD_SERVE, 32'sh1234_5678);     // both queues empty
        send_cmd(CMD_UNUSED, -32'sd1);           // ignored code
        send_cmd(CMD_PUSH_NORMAL, 32'sh8000_0000);
        send_cmd(CMD_SERVE, '0);                 // normal alone
        send_cmd(CMD_PUSH_PREF, 32'sh7fff_ffff);
        send_cmd(CMD_SERVE, -32'sd1);            // preferred alone
        send_cmd(CMD_PUSH_NORMAL, -32'sd1);
        send_cmd(CMD_PUSH_NORMAL, '0);
        send_cmd(CMD_PUSH_NORMAL, 32'sd1);
        send_cmd(CMD_PUSH_PREF, 32'sh5555_5555);
        send_cmd(CMD_PUSH_PREF, 32'shaaaa_aaaa);
        send_cmd(CMD_PUSH_PREF, '0);
        send_cmd(CMD_PUSH_PREF, -32'sd1);
        send_cmd(CMD_PUSH_PREF, 32'sh8000_0000);
        // Both queues held: three preferred, one normal, then leftovers.
        repeat (8) send_cmd(CMD_SERVE, $urandom);
        wait_drained();
    endtask

    // Fills both queues past the top, then empties them completely.
    task automatic test_queue_overflow();
        repeat (DEPTH + 1) send_cmd(CMD_PUSH_NORMAL, rand_value());
        repeat (DEPTH + 1) send_cmd(CMD_PUSH_PREF, rand_value());
        repeat (2 * DEPTH + 2) send_cmd(CMD_SERVE, rand_value());
        wait_drained();
    endtask

    // Bursts of fill-heavy, drain-heavy or mixed traffic.
    task automatic test_random_traffic(input int n_items);
        int               sent;
        int               burst_len;
        int               push_pct;
        int               roll;
        logic [CMD_W-1:0] c;
        sent = 0;
        while (sent < n_items) begin
            burst_len = $urandom_range(1, 40);
            case ($urandom_range(0, 2))
                0:       push_pct = 80;
                1:       push_pct = 25;
                default: push_pct = 55;
            endcase
            repeat (burst_len) begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    c = CMD_UNUSED;
                end else if ($urandom_range(0, 99) < push_pct) begin
                    c = $urandom_range(0, 1) ? CMD_PUSH_PREF : CMD_PUSH_NORMAL;
                end else begin
                    c = CMD_SERVE;
                end
                send_cmd(c, rand_value());
                if (c != CMD_UNUSED) sent++;
            end
        end
    endtask

    // Stimulus sequence and final verdict.
    initial begin
        i_rst_n            = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.command    = CMD_PUSH_NORMAL;
        cmd_bus.push_value = '0;
        turn               = TURN_RESET;
        fail_count         = 0;
        send_idle_pct      = 10;
        recv_idle_pct      = 88;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_queue_overflow();
        test_random_traffic(290);
        wait_drained();

        send_idle_pct = 88;
        recv_idle_pct = 10;
        test_random_traffic(300);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_queue_overflow();
        test_random_traffic(300);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (pending_beats.size() != 0) begin
            fail_count++;
            $display("%0d predicted beats never arrived", pending_beats.size());
        end
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
sv/tqws_pkg.sv
sv/tqws_if.sv
sv/tqws_front.sv
sv/tqws_queue.sv
sv/tqws_back.sv
sv/two_queue_weighted_server_core.sv
verif/tb_top.sv
